// ===== sv/lebd_pkg.sv =====
// ----------------------------------------------------------------------------
// lebd_pkg - shared types and constants of the LEB128 stream decoder
// Request payloads, the command passed from the front end to the back end,
// status codes and fixed field widths.
// ----------------------------------------------------------------------------
package lebd_pkg;

    // Width of the byte counter and of the num_bytes field.
    localparam int LEN_W = 5;
    // Bit position inside a value of at most 64 bits.
    localparam int POS_W = 6;
    // Index of a 7-bit payload group inside a value of at most 64 bits.
    localparam int IDX_W = 4;
    // Reset value of the max_bytes register.
    localparam logic [LEN_W-1:0] MAX_BYTES_RESET = 5'd24;

    // Configuration register indexes.
    localparam logic REG_MAX_BYTES = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       signed_mode;
        logic       last_in_buffer;
    } byte_req_t;

    typedef struct packed {
        logic [63:0]      value;
        logic [LEN_W-1:0] num_bytes;
        status_t          status;
    } result_req_t;

    // One classified byte, as the back end needs it.
    typedef struct packed {
        logic             merge;   // OR the group into the accumulator
        logic             emit;    // this byte completes a result
        status_t          status;
        logic [LEN_W-1:0] length;
        logic             ext;     // sign-extend from pos upwards
        logic [POS_W-1:0] pos;
        logic [IDX_W-1:0] idx;
        logic [6:0]       group;
    } cmd_t;

endpackage

// ===== sv/lebd_front.sv =====
// ----------------------------------------------------------------------------
// lebd_front - byte classifier
// Accepts bytes, keeps the byte count, latched mode and max_bytes register,
// and turns each byte into a command for the back end.
// ----------------------------------------------------------------------------
module lebd_front
    import lebd_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  byte_req_t        byte_data,
    input  logic             cfg_write,
    input  logic [LEN_W-1:0] cfg_wdata,
    output logic [LEN_W-1:0] max_bytes,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  logic             queue_full
);

    localparam int DATA_GROUPS = (VALUE_BITS + 6) / 7;
    localparam int POS_MAX     = VALUE_BITS - 1;

    logic [LEN_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic             mode_reg, mode_next;
    logic [LEN_W-1:0] max_bytes_reg, max_bytes_next;
    logic             accept;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign cmd_valid  = accept;
    assign max_bytes  = max_bytes_reg;

    always_comb
    begin
        logic [LEN_W-1:0] n;
        logic             mode;
        logic             in_data;
        logic             more;
        logic             at_limit;
        logic [7:0]       pos7;
        logic [7:0]       b;

        b        = byte_data.data_byte;
        n        = bytes_seen_reg + 5'd1;
        mode     = (bytes_seen_reg == '0) ? byte_data.signed_mode : mode_reg;
        in_data  = bytes_seen_reg < LEN_W'(DATA_GROUPS);
        more     = b[7];
        at_limit = n >= max_bytes_reg;
        pos7     = {n, 3'b000} - {3'b000, n};

        cmd        = '0;
        cmd.group  = b[6:0];
        cmd.idx    = bytes_seen_reg[IDX_W-1:0];
        cmd.length = n;
        cmd.status = ST_OK;

        if (in_data)
        begin
            cmd.merge = 1'b1;
            if (!more)
            begin
                cmd.emit = 1'b1;
                cmd.ext  = mode && b[6];
                cmd.pos  = (pos7 > 8'(POS_MAX)) ? POS_W'(POS_MAX) : pos7[POS_W-1:0];
            end
            else if (mode)
            begin
                // Signed: the buffer end takes precedence over the length limit.
                if (byte_data.last_in_buffer)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_TRUNCATED;
                end
                else if (at_limit)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_TOO_LONG;
                    cmd.length = max_bytes_reg;
                end
            end
            else
            begin
                if (at_limit)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_TOO_LONG;
                    cmd.length = max_bytes_reg;
                end
                else if (byte_data.last_in_buffer)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_TRUNCATED;
                end
            end
        end
        else
        begin
            // Beyond the value width only padding bytes are allowed.
            if (mode && (b == 8'h00 || b == 8'h40))
            begin
                cmd.emit = 1'b1;
                cmd.ext  = b[6];
                cmd.pos  = POS_W'(POS_MAX);
            end
            else if (!mode && b == 8'h00)
            begin
                cmd.emit = 1'b1;
            end
            else if (b != 8'h80)
            begin
                cmd.emit   = 1'b1;
                cmd.status = ST_OVERFLOW;
            end
            else if (at_limit)
            begin
                cmd.emit   = 1'b1;
                cmd.status = ST_TOO_LONG;
                cmd.length = max_bytes_reg;
            end
            else if (byte_data.last_in_buffer)
            begin
                cmd.emit   = 1'b1;
                cmd.status = ST_TRUNCATED;
            end
        end

        bytes_seen_next = bytes_seen_reg;
        mode_next       = mode_reg;
        if (accept)
        begin
            bytes_seen_next = cmd.emit ? '0 : n;
            mode_next       = mode;
        end

        max_bytes_next = cfg_write ? cfg_wdata : max_bytes_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            mode_reg       <= 1'b0;
            max_bytes_reg  <= MAX_BYTES_RESET;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            mode_reg       <= mode_next;
            max_bytes_reg  <= max_bytes_next;
        end
    end

endmodule

// ===== sv/lebd_queue.sv =====
// ----------------------------------------------------------------------------
// lebd_queue - two-entry command queue
// Decouples the classifier from the accumulator so each side can stall alone.
// ----------------------------------------------------------------------------
module lebd_queue
    import lebd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/lebd_back.sv =====
// ----------------------------------------------------------------------------
// lebd_back - accumulator and result register
// Merges payload groups into the accumulator, applies sign extension and
// holds each finished result until it is taken.
// ----------------------------------------------------------------------------
module lebd_back
    import lebd_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        result_valid,
    input  logic        result_ready,
    output result_req_t result_data
);

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  out_valid_reg, out_valid_next;
    result_req_t           out_data_reg, out_data_next;

    assign cmd_pop      = cmd_valid && (!cmd.emit || !out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    always_comb
    begin
        logic [6:0]              sh;
        logic [VALUE_BITS+6:0]   placed;
        logic [VALUE_BITS-1:0]   merged;
        logic [VALUE_BITS-1:0]   ext_mask;
        logic [VALUE_BITS-1:0]   final_value;

        sh       = {cmd.idx, 3'b000} - {3'b000, cmd.idx};
        placed   = (VALUE_BITS + 7)'(cmd.group) << sh;
        merged   = cmd.merge ? (acc_reg | placed[VALUE_BITS-1:0]) : acc_reg;
        ext_mask = cmd.ext ? ({VALUE_BITS{1'b1}} << cmd.pos) : '0;

        final_value = (cmd.status == ST_OK) ? (merged | ext_mask) : '0;

        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;

        if (cmd_pop)
        begin
            if (cmd.emit)
            begin
                acc_next                = '0;
                out_valid_next          = 1'b1;
                out_data_next.value     = 64'(final_value);
                out_data_next.num_bytes = cmd.length;
                out_data_next.status    = cmd.status;
            end
            else
            begin
                acc_next = merged;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A completed number always reaches the result register.
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.emit |=> out_valid_reg)
        else $error("emitted command did not produce a result");

    // The accumulator starts empty for the number after a result.
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.emit |=> acc_reg == '0)
        else $error("accumulator not cleared after a result");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != ST_OK |-> out_data_reg.value == '0)
        else $error("error result with non-zero value");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_ready |=> $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

// ===== sv/leb128_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// leb128_stream_decoder - streaming LEB128 decoder, unsigned or signed
// Takes one encoded byte per request and returns one result per number:
// the decoded value, its length in bytes and a status code.
//
//   Channel   Direction  Handshake                       Payload
//   byte      in         byte_valid / byte_ready         byte_data (byte_req_t)
//   result    out        result_valid / result_ready     result_data (result_req_t)
//   config    in         APB: psel, penable, pwrite ...  pwdata[4:0] max_bytes
//
// One byte request is taken every clock cycle while the queue is not full; the
// classifier is combinational, and the command for the last byte of a number
// is registered in the queue and then in the result register before
// result_valid rises. Reset clears the byte count, queue, accumulator and
// result valid, and sets max_bytes to 24. A stalled result side fills the
// two-entry queue and then holds byte_ready low; bytes that only extend the
// number keep draining while a result waits.
// ----------------------------------------------------------------------------
module leb128_stream_decoder
    import lebd_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  byte_req_t   byte_data,
    output logic        result_valid,
    input  logic        result_ready,
    output result_req_t result_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             cfg_write;
    logic [LEN_W-1:0] max_bytes;
    logic             push;
    cmd_t             push_cmd;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    cmd_t             head_cmd;

    // The APB port never inserts wait states. Only register index zero exists;
    // writes to the upper word are ignored and read back as zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_BYTES);
    assign prdata    = (paddr[2] == REG_MAX_BYTES) ? 32'(max_bytes) : 32'd0;

    // The front end owns everything that decides where a number ends, so the
    // back end only has to merge groups and build results.
    lebd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .cfg_write  (cfg_write),
        .cfg_wdata  (pwdata[LEN_W-1:0]),
        .max_bytes  (max_bytes),
        .cmd_valid  (push),
        .cmd        (push_cmd),
        .queue_full (queue_full)
    );

    lebd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lebd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - regression for the LEB128 stream decoder
// Byte requests go in through a valid/ready channel, decoded numbers come
// back on a second one, and max_bytes is set over the APB port. An in-house
// model of the decoder predicts every result. A short directed table comes
// first, then random numbers under several max_bytes settings. Both channels
// idle at random, except in two phases.
// ----------------------------------------------------------------------------
module testbench;
    import lebd_pkg::*;

    // A value of 64 bits holds ten 7-bit groups, the last one only in part.
    localparam int VALUE_W         = 64;
    localparam int STALL_LIMIT     = 2000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 140;
    // Quiet cycles waited once every owed number has come back.
    localparam int SETTLE_CYCLES   = 8;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    byte_req_t   byte_data    = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_req_t result_data;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    leb128_stream_decoder #(
        .VALUE_BITS (VALUE_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decoder state as the testbench sees it. It moves on every byte request
    // that the block accepts, never on one that is merely offered.
    // ------------------------------------------------------------------------
    logic [63:0] acc_value;
    logic [4:0]  bytes_taken;
    logic        number_signed;
    logic        sign_bit;
    logic [4:0]  max_bytes_cfg;

    // Decoded numbers still owed by the block, oldest first.
    result_req_t awaited_numbers[$];

    int  error_count    = 0;
    int  bytes_accepted = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    int  settings_used  = 0;
    // When clear, neither side inserts gaps, so the block runs flat out.
    bit  idle_on        = 1'b1;

    // Fills every bit from pos upwards when a signed number ends negative.
    // Positions past the top bit are clamped so that bit 63 still carries
    // the sign.
    function automatic logic [63:0] sign_fill(input logic [63:0] v, input int unsigned pos);
        int unsigned p;
        p = (pos > VALUE_W - 1) ? VALUE_W - 1 : pos;
        if (number_signed && sign_bit)
            v = v | ~((64'd1 << p) - 64'd1);
        return v;
    endfunction

    // Takes one accepted byte request and returns 1 with the decoded number
    // when this byte completes it, either normally or with an error.
    function automatic bit decode_byte(input byte_req_t req, output result_req_t res);
        logic [6:0]  grp;
        bit          more;
        int unsigned n;
        int unsigned shift;
        int unsigned len;
        bit          done;
        status_t     st;
        logic [63:0] val;
        grp   = req.data_byte[6:0];
        more  = req.data_byte[7];
        done  = 1'b0;
        st    = ST_OK;
        val   = '0;
        res   = '0;
        if (bytes_taken == 0)
            number_signed = req.signed_mode;
        n     = bytes_taken + 1;
        len   = n;
        shift = 7 * (n - 1);
        if (shift < VALUE_W)
        begin
            // Groups that straddle bit 63 lose their upper bits here.
            acc_value = acc_value | (64'(grp) << shift);
            sign_bit  = grp[6];
            if (!more)
            begin
                done = 1'b1;
                val  = sign_fill(acc_value, 7 * n);
            end
            // Signed numbers report the end of the buffer before the limit,
            // unsigned ones the other way round.
            else if (number_signed && req.last_in_buffer)
            begin
                done = 1'b1;
                st   = ST_TRUNCATED;
            end
            else if (n >= max_bytes_cfg)
            begin
                done = 1'b1;
                st   = ST_TOO_LONG;
                len  = max_bytes_cfg;
            end
            else if (req.last_in_buffer)
            begin
                done = 1'b1;
                st   = ST_TRUNCATED;
            end
        end
        else
        begin
            // All 64 bits are filled: only padding bytes are legal now.
            if (number_signed)
                sign_bit = grp[6];
            if (req.data_byte == 8'h00 ||
                (number_signed && req.data_byte == 8'h40))
            begin
                done = 1'b1;
                val  = number_signed ? sign_fill(acc_value, VALUE_W) : acc_value;
            end
            else if (req.data_byte != 8'h80)
            begin
                done = 1'b1;
                st   = ST_OVERFLOW;
            end
            else if (n >= max_bytes_cfg)
            begin
                done = 1'b1;
                st   = ST_TOO_LONG;
                len  = max_bytes_cfg;
            end
            else if (req.last_in_buffer)
            begin
                done = 1'b1;
                st   = ST_TRUNCATED;
            end
        end
        if (done)
        begin
            res.value     = val;
            res.num_bytes = len[4:0];
            res.status    = st;
            acc_value     = '0;
            bytes_taken   = '0;
            sign_bit      = 1'b0;
        end
        else
        begin
            bytes_taken = n[4:0];
        end
        return done;
    endfunction

    // ------------------------------------------------------------------------
    // Byte request side. Inputs change only just after a rising edge, so the
    // handshake is judged at the falling edge and completes at the next
    // rising one.
    // ------------------------------------------------------------------------
    task automatic send_byte(input byte_req_t req, output bit has_res, output result_req_t res);
        int gap;
        bit taken;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= req;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = byte_ready;
            @(posedge clk);
        end
        bytes_accepted++;
        has_res = decode_byte(req, res);
    endtask

    // Stops sending and waits until every owed number has come back.
    task automatic drain_numbers();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (awaited_numbers.size() != 0)
            @(posedge clk);
    endtask

    // Ends a half-finished number with a single zero byte, which is a legal
    // last byte both inside the value and in the padding.
    task automatic close_number();
        bit          got;
        result_req_t res;
        if (bytes_taken != 0)
        begin
            send_byte('{data_byte: 8'h00, signed_mode: 1'b0, last_in_buffer: 1'b1}, got, res);
            if (got)
                awaited_numbers.push_back(res);
        end
    endtask

    // Writes max_bytes once the block is idle, then reads it back.
    task automatic set_max_bytes(input logic [4:0] v);
        bit          ok;
        logic [31:0] rd;
        close_number();
        drain_numbers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({REG_MAX_BYTES, 2'b00});
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = pready;
            @(posedge clk);
        end
        // Straight into the read-back: select stays high, a new setup phase.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = pready;
            rd = prdata;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[4:0] !== v)
        begin
            $display("%0t: max_bytes read-back expected %0d got %0d", $time, v, rd[4:0]);
            error_count++;
        end
        max_bytes_cfg = v;
        settings_used++;
    endtask

    // One random number: mostly well-formed encodings of random length and
    // content, some running into the padding, the limit or a buffer end, and
    // a share of plain noise.
    task automatic send_random_number();
        bit          sgn;
        bit          got;
        int          kind;
        int          len;
        int          k;
        byte_req_t   req;
        result_req_t res;
        sgn  = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 99);
        got  = 1'b0;
        if (kind < 8)
        begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
            begin
                req = byte_req_t'(10'($urandom));
                send_byte(req, got, res);
                if (got)
                    awaited_numbers.push_back(res);
            end
            return;
        end
        if (kind < 55)
            len = $urandom_range(1, 10);
        else if (kind < 80)
            len = $urandom_range(8, 10);
        else
            len = $urandom_range(11, int'(max_bytes_cfg) + 2);
        for (k = 1; k <= len && !got; k++)
        begin
            if (7 * (k - 1) < VALUE_W)
                req.data_byte = {1'(k < len), 7'($urandom)};
            else if (k < len)
                req.data_byte = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'h80;
            else if ($urandom_range(0, 6) == 0)
                req.data_byte = 8'($urandom);
            else
                req.data_byte = (sgn && $urandom_range(0, 1)) ? 8'h40 : 8'h00;
            // The mode only counts on the first byte; later ones are noise.
            req.signed_mode    = (k == 1) ? sgn : 1'($urandom);
            req.last_in_buffer = (k == len) ? 1'($urandom) : ($urandom_range(0, 29) == 0);
            send_byte(req, got, res);
            if (got)
                awaited_numbers.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, every result compared field by
    // field with the oldest owed number.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int          gap;
        bit          got;
        result_req_t want;
        @(posedge rst_n);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            got = 1'b0;
            while (!got)
            begin
                @(negedge clk);
                if (result_valid)
                begin
                    got = 1'b1;
                    if (awaited_numbers.size() == 0)
                    begin
                        $display("%0t: unexpected result, expected none got %h/%0d/%0d",
                                 $time, result_data.value, result_data.num_bytes,
                                 result_data.status);
                        error_count++;
                    end
                    else
                    begin
                        want = awaited_numbers.pop_front();
                        status_seen[want.status]++;
                        if (result_data.value !== want.value)
                        begin
                            $display("%0t: value expected %h got %h",
                                     $time, want.value, result_data.value);
                            error_count++;
                        end
                        if (result_data.num_bytes !== want.num_bytes)
                        begin
                            $display("%0t: num_bytes expected %0d got %0d",
                                     $time, want.num_bytes, result_data.num_bytes);
                            error_count++;
                        end
                        if (result_data.status !== want.status)
                        begin
                            $display("%0t: status expected %0d got %0d",
                                     $time, want.status, result_data.status);
                            error_count++;
                        end
                    end
                end
                @(posedge clk);
            end
        end
    end

    // Watchdog: a long run of cycles in which neither channel moves a
    // request means the block has hung.
    int stall_cycles = 0;

    always @(negedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (result_valid && result_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
                $display("leb128_stream_decoder regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table: a row either writes max_bytes or sends one byte. Rows
    // with an obvious answer carry it; the others are left to the predictor.
    // ------------------------------------------------------------------------
    typedef struct {
        bit          is_cfg;
        logic [4:0]  cfg;
        byte_req_t   req;
        bit          typed;
        result_req_t want;
    } dir_row_t;

    dir_row_t directed_rows[$];

    function automatic void add_cfg(input logic [4:0] v);
        dir_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg    = v;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_req(input logic [7:0] d, input bit s, input bit l);
        dir_row_t row;
        row     = '{default: '0};
        row.req = '{data_byte: d, signed_mode: s, last_in_buffer: l};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [7:0] d, input bit s, input bit l,
                                        input logic [63:0] v, input int len,
                                        input status_t st);
        dir_row_t row;
        row       = '{default: '0};
        row.req   = '{data_byte: d, signed_mode: s, last_in_buffer: l};
        row.typed = 1'b1;
        row.want  = '{value: v, num_bytes: 5'(len), status: st};
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        bit          got;
        result_req_t res;
        logic [4:0]  phase_max[NUM_PHASES];
        logic [4:0]  setting;
        int          start_count;

        acc_value     = '0;
        bytes_taken   = '0;
        number_signed = 1'b0;
        sign_bit      = 1'b0;
        max_bytes_cfg = MAX_BYTES_RESET;

        // Single-byte numbers at the reset limit: zero, the largest group,
        // minus one, minus 64, and a buffer that ends on a continuation.
        add_checked(8'h00, 1'b0, 1'b1, 64'h0, 1, ST_OK);
        add_checked(8'h7F, 1'b0, 1'b0, 64'd127, 1, ST_OK);
        add_checked(8'h7F, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK);
        add_checked(8'h40, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFC0, 1, ST_OK);
        add_checked(8'h80, 1'b0, 1'b1, 64'h0, 1, ST_TRUNCATED);
        add_checked(8'h80, 1'b1, 1'b1, 64'h0, 1, ST_TRUNCATED);
        // Lowest limit: the largest unsigned number just fits, and a signed
        // continuation on the limit that is also the buffer end is reported
        // as a buffer end.
        add_cfg(5'd10);
        repeat (9) add_req(8'hFF, 1'b0, 1'b0);
        add_checked(8'h01, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 10, ST_OK);
        repeat (9) add_req(8'hFF, 1'b1, 1'b0);
        add_checked(8'h81, 1'b1, 1'b1, 64'h0, 10, ST_TRUNCATED);
        // Highest limit: a signed zero padded out and closed with 0x40, which
        // sets only the top bit.
        add_cfg(5'd31);
        repeat (10) add_req(8'h80, 1'b1, 1'b0);
        add_checked(8'h40, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 11, ST_OK);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                set_max_bytes(directed_rows[i].cfg);
            else
            begin
                send_byte(directed_rows[i].req, got, res);
                if (directed_rows[i].typed)
                    awaited_numbers.push_back(directed_rows[i].want);
                else if (got)
                    awaited_numbers.push_back(res);
            end
        end

        // Random phases, the extremes of max_bytes among them. Two phases
        // run with no idling on either side.
        phase_max = '{5'd10, 5'd31, 5'd17, 5'd0, 5'd0, 5'd0, 5'd24, 5'd12};
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            setting = (phase >= 3 && phase <= 5) ? 5'($urandom_range(10, 31)) : phase_max[phase];
            set_max_bytes(setting);
            idle_on     = (phase != 2 && phase != 5);
            start_count = bytes_accepted;
            while (bytes_accepted - start_count < ITEMS_PER_PHASE)
            begin
                send_random_number();
                // Now and then let the result side catch up completely.
                if ($urandom_range(0, 39) == 0)
                    drain_numbers();
            end
        end

        close_number();
        drain_numbers();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d byte requests under %0d max_bytes settings.",
                 bytes_accepted, settings_used);
        $display("Numbers returned: %0d ok, %0d cut short, %0d too long, %0d overflowed.",
                 status_seen[ST_OK], status_seen[ST_TRUNCATED],
                 status_seen[ST_TOO_LONG], status_seen[ST_OVERFLOW]);
        if (error_count == 0)
            $display("leb128_stream_decoder regression: pass");
        else
            $display("leb128_stream_decoder regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lebd_pkg.sv
sv/lebd_front.sv
sv/lebd_queue.sv
sv/lebd_back.sv
sv/leb128_stream_decoder.sv
dv/testbench.sv
